/* sv/lzss_flag_byte_decoder_top_assert.svh */
// Assertion helpers for the LZSS flag-byte decoder.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef LZSS_FLAG_BYTE_DECODER_TOP_ASSERT_SVH
`define LZSS_FLAG_BYTE_DECODER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LFBD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LFBD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lfbd_pkg.sv */
`timescale 1ns / 1ps

package lfbd_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 4096;

  // bytes in one packed result word
  localparam logic [2:0] FULL_COUNT = 3'd4;

  localparam logic [7:0] MAGIC [4] = '{8'h4C, 8'h5A, 8'h37, 8'h37};  // "LZ77"

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_MAGIC = 3'd1,
    STAT_SHORT     = 3'd2,
    STAT_TRUNC     = 3'd3,
    STAT_ZERO      = 3'd4,
    STAT_RANGE     = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    FSM_IDLE   = 4'b0001,
    FSM_DECODE = 4'b0010,
    FSM_READ   = 4'b0100,
    FSM_WRITE  = 4'b1000
  } fsm_e;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_TOKEN  = 4'b0010,
    PH_OFFHI  = 4'b0100,
    PH_LEN    = 4'b1000
  } phase_e;

endpackage

/* sv/lzss_flag_byte_decoder_top.sv */
// Each input byte is taken while idle and decoded in the decode state. A literal byte gives
// one byte; header, flag and offset bytes only give the empty end or error result.
// A match length byte copies, one history read then one history write per copied byte,
// and gives a word per four bytes and the rest at the end. No new byte is taken until done.
// A result that cannot enter the output register holds the sequencer.
// Reset: asynchronous, active low; clears control state, no clearing pass over history.
`timescale 1ns / 1ps

`include "lzss_flag_byte_decoder_top_assert.svh"

module lzss_flag_byte_decoder_top #(
  parameter int unsigned WINDOW_DEPTH = lfbd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // compressed byte stream
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  // packed decoded bytes
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_bytes_o,
  output logic [2:0]  byte_count_o,
  output logic        run_last_o,
  output logic        stream_end_o,
  output logic [2:0]  status_o
);

  // history pointer, produced count (saturating at the window) and compare widths
  localparam int unsigned PTR_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > 16) ? CNT_W : 16;
  localparam int unsigned SUM_W = CMP_W + 1;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  lfbd_pkg::fsm_e   state_q, state_d;
  lfbd_pkg::phase_e phase_q, phase_d;
  logic [1:0]       hdr_cnt_q, hdr_cnt_d;
  logic [7:0]       flag_q, flag_d;
  logic [3:0]       fidx_q, fidx_d;       // 8 means the group is used up
  logic [7:0]       off_lo_q, off_lo_d;
  logic [7:0]       off_hi_q, off_hi_d;
  logic [PTR_W-1:0] wp_q, wp_d;
  logic [CNT_W-1:0] prod_q, prod_d;
  logic             err_q, err_d;          // draining after an error
  logic [7:0]       len_q, len_d;          // bytes of the match still to copy
  logic [31:0]      word_q, word_d;        // packing word, zero above fill
  logic [1:0]       fill_q, fill_d;

  logic [7:0]       in_byte_q;
  logic             in_last_q;

  // output register
  logic             out_valid_q;
  logic [31:0]      out_bytes_q;
  logic [2:0]       out_count_q;
  logic             out_last_q;
  logic             out_end_q;
  lfbd_pkg::status_e out_status_q;

  // history window
  logic [7:0]       hist_mem [WINDOW_DEPTH];
  logic [7:0]       rdata_q;
  logic             mem_we;
  logic [7:0]       mem_wdata;
  logic             rd_en;

  // result handed to the output register
  logic             emit;
  logic [31:0]      em_bytes;
  logic [2:0]       em_count;
  logic             em_last;
  logic             em_end;
  lfbd_pkg::status_e em_status;

  logic             slot_free;
  logic             hold;
  logic             in_xfer;
  logic             restart;
  logic             do_finish;
  lfbd_pkg::status_e fin_status;

  // shared address unit signals
  logic [CMP_W-1:0] off_cmp;
  logic [CMP_W-1:0] prod_cmp;
  logic [SUM_W-1:0] wp_ext;
  logic [SUM_W-1:0] off_ext;
  logic [SUM_W-1:0] src_full;
  logic [PTR_W-1:0] src_addr;
  logic [PTR_W:0]   wp_inc;
  logic [PTR_W-1:0] wp_next;
  logic [CNT_W-1:0] prod_next;
  logic [31:0]      word_next;
  logic             copy_final;

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  // Only idle takes a byte; a waiting result sits in the output register meanwhile.
  assign in_stall_o = (state_q != lfbd_pkg::FSM_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  // A step that produces a result waits until the output register can take it.
  assign hold       = emit && !slot_free;

  // ---------------------------------------------------------------------------
  // Address unit: source of the copy, next write pointer, saturated count
  // ---------------------------------------------------------------------------
  assign off_cmp  = CMP_W'({off_hi_q, off_lo_q});
  assign prod_cmp = CMP_W'(prod_q);
  assign wp_ext   = SUM_W'(wp_q);
  assign off_ext  = SUM_W'(off_cmp);
  // offset never exceeds the window, so one wrap is enough
  assign src_full = (wp_ext >= off_ext) ? (wp_ext - off_ext)
                                        : (wp_ext + SUM_W'(WINDOW_DEPTH) - off_ext);
  assign src_addr = src_full[PTR_W-1:0];

  assign wp_inc    = {1'b0, wp_q} + (PTR_W + 1)'(1);
  assign wp_next   = (wp_inc >= (PTR_W + 1)'(WINDOW_DEPTH)) ? '0 : wp_inc[PTR_W-1:0];
  assign prod_next = (prod_q < CNT_W'(WINDOW_DEPTH)) ? (prod_q + CNT_W'(1)) : prod_q;

  assign word_next  = word_q | (32'(rdata_q) << {fill_q, 3'b000});
  assign copy_final = (len_q == 8'd1);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    hdr_cnt_d  = hdr_cnt_q;
    flag_d     = flag_q;
    fidx_d     = fidx_q;
    off_lo_d   = off_lo_q;
    off_hi_d   = off_hi_q;
    wp_d       = wp_q;
    prod_d     = prod_q;
    err_d      = err_q;
    len_d      = len_q;
    word_d     = word_q;
    fill_d     = fill_q;
    mem_we     = 1'b0;
    mem_wdata  = in_byte_q;
    rd_en      = 1'b0;
    emit       = 1'b0;
    em_bytes   = '0;
    em_count   = '0;
    em_last    = 1'b1;
    em_end     = 1'b0;
    em_status  = lfbd_pkg::STAT_OK;
    restart    = 1'b0;
    do_finish  = 1'b0;
    fin_status = lfbd_pkg::STAT_OK;

    unique case (state_q)
      lfbd_pkg::FSM_IDLE: begin
        if (in_xfer) begin
          state_d = lfbd_pkg::FSM_DECODE;
        end
      end

      lfbd_pkg::FSM_DECODE: begin
        state_d = lfbd_pkg::FSM_IDLE;
        if (err_q) begin
          // drop bytes until the end of the failed stream
          restart = in_last_q;
        end else begin
          unique case (phase_q)
            lfbd_pkg::PH_HEADER: begin
              if (in_last_q && (hdr_cnt_q != 2'd3)) begin
                do_finish  = 1'b1;
                fin_status = lfbd_pkg::STAT_SHORT;
              end else if (in_byte_q != lfbd_pkg::MAGIC[hdr_cnt_q]) begin
                do_finish  = 1'b1;
                fin_status = lfbd_pkg::STAT_BAD_MAGIC;
              end else begin
                hdr_cnt_d = hdr_cnt_q + 2'd1;
                if (hdr_cnt_q == 2'd3) begin
                  phase_d = lfbd_pkg::PH_TOKEN;
                end
                do_finish = in_last_q;
              end
            end

            lfbd_pkg::PH_TOKEN: begin
              if (fidx_q[3]) begin
                // new flag byte opens a group
                flag_d    = in_byte_q;
                fidx_d    = '0;
                do_finish = in_last_q;
              end else if (!flag_q[fidx_q[2:0]]) begin
                // literal
                mem_we   = 1'b1;
                wp_d     = wp_next;
                prod_d   = prod_next;
                fidx_d   = fidx_q + 4'd1;
                emit     = 1'b1;
                em_bytes = 32'(in_byte_q);
                em_count = 3'd1;
                em_end   = in_last_q;
                restart  = in_last_q;
              end else begin
                off_lo_d   = in_byte_q;
                phase_d    = lfbd_pkg::PH_OFFHI;
                do_finish  = in_last_q;
                fin_status = lfbd_pkg::STAT_TRUNC;
              end
            end

            lfbd_pkg::PH_OFFHI: begin
              off_hi_d   = in_byte_q;
              phase_d    = lfbd_pkg::PH_LEN;
              do_finish  = in_last_q;
              fin_status = lfbd_pkg::STAT_TRUNC;
            end

            lfbd_pkg::PH_LEN: begin
              phase_d = lfbd_pkg::PH_TOKEN;
              fidx_d  = fidx_q + 4'd1;
              if ((off_cmp == '0) || (in_byte_q == 8'd0)) begin
                do_finish  = 1'b1;
                fin_status = lfbd_pkg::STAT_ZERO;
              end else if (off_cmp > prod_cmp) begin
                do_finish  = 1'b1;
                fin_status = lfbd_pkg::STAT_RANGE;
              end else begin
                len_d   = in_byte_q;
                word_d  = '0;
                fill_d  = '0;
                state_d = lfbd_pkg::FSM_READ;
              end
            end

            default: begin
              phase_d = lfbd_pkg::PH_HEADER;
            end
          endcase
        end
      end

      lfbd_pkg::FSM_READ: begin
        rd_en   = 1'b1;
        state_d = lfbd_pkg::FSM_WRITE;
      end

      lfbd_pkg::FSM_WRITE: begin
        // copied byte goes back into the window, so overlapping copies repeat
        mem_we    = 1'b1;
        mem_wdata = rdata_q;
        wp_d      = wp_next;
        prod_d    = prod_next;
        len_d     = len_q - 8'd1;
        if (copy_final || (fill_q == 2'd3)) begin
          emit     = 1'b1;
          em_bytes = word_next;
          em_count = {1'b0, fill_q} + 3'd1;
          em_last  = copy_final;
          em_end   = copy_final && in_last_q;
          word_d   = '0;
          fill_d   = '0;
        end else begin
          word_d = word_next;
          fill_d = fill_q + 2'd1;
        end
        if (copy_final) begin
          state_d = lfbd_pkg::FSM_IDLE;
          restart = in_last_q;
        end else begin
          state_d = lfbd_pkg::FSM_READ;
        end
      end

      default: begin
        state_d = lfbd_pkg::FSM_IDLE;
      end
    endcase

    // stream end or error: a single empty result
    if (do_finish) begin
      emit      = 1'b1;
      em_bytes  = '0;
      em_count  = '0;
      em_last   = 1'b1;
      em_end    = 1'b1;
      em_status = fin_status;
      if (in_last_q || (fin_status == lfbd_pkg::STAT_OK)) begin
        restart = 1'b1;
      end else begin
        err_d = 1'b1;
      end
    end

    if (restart) begin
      hdr_cnt_d = '0;
      phase_d   = lfbd_pkg::PH_HEADER;
      flag_d    = '0;
      fidx_d    = 4'd8;
      off_lo_d  = '0;
      off_hi_d  = '0;
      wp_d      = '0;
      prod_d    = '0;
      err_d     = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lfbd_pkg::FSM_IDLE;
      phase_q   <= lfbd_pkg::PH_HEADER;
      hdr_cnt_q <= '0;
      fidx_q    <= 4'd8;
      wp_q      <= '0;
      prod_q    <= '0;
      err_q     <= 1'b0;
      len_q     <= '0;
      fill_q    <= '0;
    end else if (!hold) begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      fidx_q    <= fidx_d;
      wp_q      <= wp_d;
      prod_q    <= prod_d;
      err_q     <= err_d;
      len_q     <= len_d;
      fill_q    <= fill_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (emit && slot_free) || (out_valid_q && out_stall_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
    if (!hold) begin
      flag_q   <= flag_d;
      off_lo_q <= off_lo_d;
      off_hi_q <= off_hi_d;
      word_q   <= word_d;
    end
    if (emit && slot_free) begin
      out_bytes_q  <= em_bytes;
      out_count_q  <= em_count;
      out_last_q   <= em_last;
      out_end_q    <= em_end;
      out_status_q <= em_status;
    end
  end

  // history window: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we && !hold) begin
      hist_mem[wp_q] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= hist_mem[src_addr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_bytes_o  = out_bytes_q;
  assign byte_count_o = out_count_q;
  assign run_last_o   = out_last_q;
  assign stream_end_o = out_end_q;
  assign status_o     = out_status_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `LFBD_ASSERT_NOW(a_partial_only_last, out_valid_o && !run_last_o,
                   byte_count_o == lfbd_pkg::FULL_COUNT, "short word before end of run")
  `LFBD_ASSERT_NOW(a_end_is_last, out_valid_o && stream_end_o, run_last_o,
                   "stream end without run end")
  `LFBD_ASSERT_NOW(a_error_empty, out_valid_o && (status_o != lfbd_pkg::STAT_OK),
                   (byte_count_o == 3'd0) && stream_end_o, "error transfer carries data")
  `LFBD_ASSERT_NOW(a_copy_in_range, state_q == lfbd_pkg::FSM_READ,
                   (off_cmp != '0) && (off_cmp <= prod_cmp), "copy offset outside history")
  `LFBD_ASSERT_NEXT(a_drain_holds, (state_q == lfbd_pkg::FSM_DECODE) && err_q && !in_last_q,
                    err_q && (state_q == lfbd_pkg::FSM_IDLE), "drain left early")

endmodule
